### rtl/bhd_pkg.sv
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared widths and codes for the message header deframer and its channels.
// ----------------------------------------------------------------------------
package bhd_pkg;

  localparam int BYTE_W     = 8;
  localparam int LENGTH_W   = 16;
  localparam int MARKER_LEN = 16;
  // Header positions run from the first marker byte up to the type byte.
  localparam int POS_W      = $clog2(MARKER_LEN + 3);

  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;

  // Input command codes.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_OPEN = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  // Error codes.
  localparam logic ERR_TOO_SHORT  = 1'b0;
  localparam logic ERR_BAD_MARKER = 1'b1;

endpackage

### rtl/bhd_in_if.sv
// ----------------------------------------------------------------------------
// bhd_in_if
// Valid/ready channel carrying stream bytes and open commands.
// ----------------------------------------------------------------------------
interface bhd_in_if;
  import bhd_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);

endinterface

### rtl/bhd_out_if.sv
// ----------------------------------------------------------------------------
// bhd_out_if
// Valid/ready channel carrying payload bytes and connection errors.
// ----------------------------------------------------------------------------
interface bhd_out_if;
  import bhd_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_of_message;
  logic              error_code;

  modport source (output valid, output kind, output payload_byte,
                  output last_of_message, output error_code, input ready);
  modport sink   (input valid, input kind, input payload_byte,
                  input last_of_message, input error_code, output ready);

endinterface

### rtl/bgp_header_deframer.sv
// ----------------------------------------------------------------------------
// bgp_header_deframer
// Strips the 16-byte marker, length and type header from a received byte
// stream and forwards the payload, flagging the last byte, or reports an error.
// ----------------------------------------------------------------------------
// The block returns at most one result beat for each input beat from an
// output register in the next cycle. The parser state is updated in the
// cycle a beat is accepted, so a new beat can follow in every cycle;
// stream.ready is high whenever the output register is empty or its beat
// is being taken in the same cycle, which sets the throughput at one byte
// per clock under no back-pressure. The length byte order is chosen by the
// length_big_endian register (cfg_write_en/cfg_write_data), which the user
// must write only while no beat is in flight; the block does not enforce it.
module bgp_header_deframer (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_write_en,
  input  logic   cfg_write_data,
  bhd_in_if.sink   stream,
  bhd_out_if.source result
);
  import bhd_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CLOSED  = 2'd2;

  logic                length_big_endian;
  logic [1:0]          phase;
  logic [1:0]          phase_next;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  logic [LENGTH_W-1:0] count;
  logic [LENGTH_W-1:0] count_next;
  logic                mismatch;
  logic                mismatch_next;

  logic                accept;
  logic                load;
  logic                res_kind_next;
  logic [BYTE_W-1:0]   res_byte_next;
  logic                res_last_next;
  logic                res_err_next;
  logic                res_valid;

  assign stream.ready = !res_valid || result.ready;
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_big_endian <= 1'b0;
    end else if (cfg_write_en) begin
      length_big_endian <= cfg_write_data;
    end
  end

  // In the payload phase, count holds the number of payload bytes still due.
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    count_next    = count;
    mismatch_next = mismatch;
    load          = 1'b0;
    res_kind_next = KIND_PAYLOAD;
    res_byte_next = '0;
    res_last_next = 1'b0;
    res_err_next  = ERR_TOO_SHORT;
    if (accept) begin
      if (stream.cmd == CMD_OPEN) begin
        phase_next    = PH_HEADER;
        pos_next      = '0;
        count_next    = '0;
        mismatch_next = 1'b0;
      end else begin
        case (phase)
          PH_HEADER: begin
            if (pos < POS_W'(MARKER_LEN)) begin
              if (stream.data_byte != MARKER_BYTE) begin
                mismatch_next = 1'b1;
              end
              pos_next = pos + POS_W'(1);
            end else if (pos == POS_W'(MARKER_LEN)) begin
              count_next = length_big_endian ? {stream.data_byte, 8'h00}
                                             : {8'h00, stream.data_byte};
              pos_next   = pos + POS_W'(1);
            end else if (pos == POS_W'(MARKER_LEN + 1)) begin
              count_next = length_big_endian ? {count[15:8], stream.data_byte}
                                             : {stream.data_byte, count[7:0]};
              pos_next   = pos + POS_W'(1);
            end else begin
              // Type byte: dropped, but the length must cover it.
              if (count <= LENGTH_W'(1)) begin
                load          = 1'b1;
                res_kind_next = KIND_ERROR;
                res_err_next  = ERR_TOO_SHORT;
                phase_next    = PH_CLOSED;
              end else begin
                count_next = count - LENGTH_W'(1);
                phase_next = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            if (count == LENGTH_W'(1)) begin
              load = 1'b1;
              if (mismatch) begin
                res_kind_next = KIND_ERROR;
                res_err_next  = ERR_BAD_MARKER;
                phase_next    = PH_CLOSED;
              end else begin
                res_byte_next = stream.data_byte;
                res_last_next = 1'b1;
                phase_next    = PH_HEADER;
                pos_next      = '0;
                count_next    = '0;
                mismatch_next = 1'b0;
              end
            end else begin
              count_next    = count - LENGTH_W'(1);
              load          = !mismatch;
              res_byte_next = stream.data_byte;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      count    <= '0;
      mismatch <= 1'b0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      count    <= count_next;
      mismatch <= mismatch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.kind            <= res_kind_next;
      result.payload_byte    <= res_byte_next;
      result.last_of_message <= res_last_next;
      result.error_code      <= res_err_next;
    end
  end

  assign result.valid = res_valid;

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> stream.ready)
    else $error("input stalled with an empty output register");

  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    (load && res_kind_next == KIND_ERROR) |=> phase == PH_CLOSED)
    else $error("error result did not close the connection");

  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    (load && res_last_next) |=> (phase == PH_HEADER && pos == '0 && !mismatch))
    else $error("parser not rearmed after the last payload byte");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> count != '0)
    else $error("payload phase with no bytes due");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_ERROR) |->
      (result.payload_byte == '0 && !result.last_of_message))
    else $error("error result carries payload fields");
`endif

endmodule
